FILE: hdl/gbs_pkg.sv
// Shared constants and controller/datapath interface types for greedy box suppression.
package gbs_pkg;

    localparam int MAX_KEPT_DEF   = 100;
    localparam int COORD_BITS_DEF = 20;

    localparam int THR_BITS   = 17;
    localparam int SCORE_BITS = 16;
    localparam int SLOT_BITS  = 7;
    localparam int IOU_SHIFT  = 16;

    localparam logic [THR_BITS-1:0] THR_RESET = 17'd29491;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // latch candidate request, clear hit flag
        logic area;        // candidate area, rewind scan index
        logic rd;          // read one kept entry and advance index
        logic commit;      // decide, update table, load result register
    } gbs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic tbl_empty;
        logic tbl_full;
        logic scan_last;   // current index is the last valid entry
        logic pipe_busy;   // compare pipeline still holds reads
        logic out_free;    // result register can take a new result
    } gbs_sts_t;

endpackage

FILE: hdl/gbs_ram.sv
// Generic simple dual-port RAM with registered read.
module gbs_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 100
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/gbs_ctrl.sv
// Sequencer for one candidate: capture, area, table scan, drain, commit.
module gbs_ctrl
    import gbs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  gbs_sts_t sts,
    output gbs_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_AREA  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_AREA;
                end
            end
            ST_AREA:
            begin
                cmd.area = 1'b1;
                // empty table: nothing to compare against; full table: candidate cannot be kept
                if (sts.tbl_empty || sts.tbl_full)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.rd = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/gbs_dp.sv
// Datapath: kept-box tables, pipelined overlap test, fill count and result register.
module gbs_dp
    import gbs_pkg::*;
#(
    parameter int MAX_KEPT   = MAX_KEPT_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic [THR_BITS-1:0]          cfg_data,
    input  logic signed [COORD_BITS-1:0] in_left,
    input  logic signed [COORD_BITS-1:0] in_top,
    input  logic signed [COORD_BITS-1:0] in_right,
    input  logic signed [COORD_BITS-1:0] in_bottom,
    input  logic [SCORE_BITS-1:0]        in_score,
    input  logic                         in_last,
    input  gbs_cmd_t                     cmd,
    output gbs_sts_t                     sts,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         out_kept,
    output logic [SLOT_BITS-1:0]         out_slot,
    output logic signed [COORD_BITS-1:0] out_left,
    output logic signed [COORD_BITS-1:0] out_top,
    output logic signed [COORD_BITS-1:0] out_right,
    output logic signed [COORD_BITS-1:0] out_bottom,
    output logic [SCORE_BITS-1:0]        out_score,
    output logic                         out_last,
    output logic [SLOT_BITS-1:0]         out_total
);

    localparam int C       = COORD_BITS;
    localparam int CNT_W   = $clog2(MAX_KEPT + 1);
    localparam int ADDR_W  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int AREA_W  = 2 * C;
    localparam int UNI_W   = AREA_W + 1;
    localparam int LO_W    = C + 1;
    localparam int HI_W    = UNI_W - LO_W;
    localparam int LHS_W   = AREA_W + IOU_SHIFT;
    localparam int RHS_W   = THR_BITS + UNI_W;
    localparam int STAGES  = 5;

    function automatic logic [C-1:0] span_of(input logic signed [C-1:0] lo,
                                             input logic signed [C-1:0] hi);
        logic [C:0] d;
        d = {hi[C-1], hi} - {lo[C-1], lo};
        if (hi > lo)
        begin
            return d[C-1:0];
        end
        return '0;
    endfunction

    function automatic logic signed [C-1:0] smax(input logic signed [C-1:0] a,
                                                 input logic signed [C-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [C-1:0] smin(input logic signed [C-1:0] a,
                                                 input logic signed [C-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // control state
    logic [THR_BITS-1:0] thr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    idx_reg;
    logic [STAGES-1:0]   vld_reg;
    logic                hit_reg;
    logic                out_valid_reg;

    // candidate
    logic signed [C-1:0]   cl_reg, ct_reg, cr_reg, cb_reg;
    logic [SCORE_BITS-1:0] score_reg;
    logic                  last_reg;
    logic [C-1:0]          cw_reg, ch_reg;
    logic [AREA_W-1:0]     area_a_reg;

    // compare pipeline
    logic [AREA_W-1:0]        lo_rd, hi_rd;
    logic signed [C-1:0]      k_left, k_top, k_right, k_bottom;
    logic [C-1:0]             iw1_reg, ih1_reg, kw1_reg, kh1_reg;
    logic [AREA_W-1:0]        inter2_reg, areab2_reg;
    logic [UNI_W-1:0]         uni3_reg;
    logic [LHS_W-1:0]         lhs3_reg, lhs4_reg;
    logic [THR_BITS+LO_W-1:0] plo4_reg;
    logic [THR_BITS+HI_W-1:0] phi4_reg;
    logic [RHS_W-1:0]         rhs;
    logic                     over;

    // result register
    logic                  kept_reg;
    logic [SLOT_BITS-1:0]  slot_reg, total_reg;
    logic signed [C-1:0]   ol_reg, ot_reg, or_reg, ob_reg;
    logic [SCORE_BITS-1:0] oscore_reg;
    logic                  olast_reg;

    logic keep;
    logic tbl_we;

    assign keep   = !hit_reg && !sts.tbl_full;
    assign tbl_we = cmd.commit && keep;

    gbs_ram #(
        .WIDTH (AREA_W),
        .DEPTH (MAX_KEPT)
    ) u_low_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata ({ct_reg, cl_reg}),
        .re    (cmd.rd),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (lo_rd)
    );

    gbs_ram #(
        .WIDTH (AREA_W),
        .DEPTH (MAX_KEPT)
    ) u_high_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata ({cb_reg, cr_reg}),
        .re    (cmd.rd),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (hi_rd)
    );

    assign k_left   = $signed(lo_rd[C-1:0]);
    assign k_top    = $signed(lo_rd[AREA_W-1:C]);
    assign k_right  = $signed(hi_rd[C-1:0]);
    assign k_bottom = $signed(hi_rd[AREA_W-1:C]);

    // threshold * union, split into two partial products one stage earlier
    assign rhs  = RHS_W'(plo4_reg) + (RHS_W'(phi4_reg) << LO_W);
    assign over = RHS_W'(lhs4_reg) > rhs;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.commit)
        begin
            if (last_reg)
            begin
                count_next = '0;
            end
            else if (keep)
            begin
                count_next = CNT_W'(count_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THR_RESET;
            count_reg     <= '0;
            idx_reg       <= '0;
            vld_reg       <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                thr_reg <= cfg_data;
            end
            count_reg <= count_next;
            if (cmd.area)
            begin
                idx_reg <= '0;
            end
            else if (cmd.rd)
            begin
                idx_reg <= CNT_W'(idx_reg + 1'b1);
            end
            vld_reg <= {vld_reg[STAGES-2:0], cmd.rd};
            if (cmd.capture)
            begin
                hit_reg <= 1'b0;
            end
            else if (vld_reg[STAGES-1] && over)
            begin
                hit_reg <= 1'b1;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cl_reg    <= in_left;
            ct_reg    <= in_top;
            cr_reg    <= in_right;
            cb_reg    <= in_bottom;
            score_reg <= in_score;
            last_reg  <= in_last;
            cw_reg    <= span_of(in_left, in_right);
            ch_reg    <= span_of(in_top, in_bottom);
        end
        if (cmd.area)
        begin
            area_a_reg <= cw_reg * ch_reg;
        end

        iw1_reg    <= span_of(smax(cl_reg, k_left), smin(cr_reg, k_right));
        ih1_reg    <= span_of(smax(ct_reg, k_top), smin(cb_reg, k_bottom));
        kw1_reg    <= span_of(k_left, k_right);
        kh1_reg    <= span_of(k_top, k_bottom);

        inter2_reg <= iw1_reg * ih1_reg;
        areab2_reg <= kw1_reg * kh1_reg;

        uni3_reg   <= UNI_W'(area_a_reg) + UNI_W'(areab2_reg) - UNI_W'(inter2_reg);
        lhs3_reg   <= {inter2_reg, {IOU_SHIFT{1'b0}}};

        plo4_reg   <= thr_reg * uni3_reg[LO_W-1:0];
        phi4_reg   <= thr_reg * uni3_reg[UNI_W-1:LO_W];
        lhs4_reg   <= lhs3_reg;

        if (cmd.commit)
        begin
            kept_reg   <= keep;
            slot_reg   <= keep ? SLOT_BITS'(count_reg) : '0;
            total_reg  <= SLOT_BITS'(keep ? CNT_W'(count_reg + 1'b1) : count_reg);
            ol_reg     <= cl_reg;
            ot_reg     <= ct_reg;
            or_reg     <= cr_reg;
            ob_reg     <= cb_reg;
            oscore_reg <= score_reg;
            olast_reg  <= last_reg;
        end
    end

    assign sts.tbl_empty = (count_reg == '0);
    assign sts.tbl_full  = (count_reg >= CNT_W'(MAX_KEPT));
    assign sts.scan_last = (CNT_W'(idx_reg + 1'b1) == count_reg);
    assign sts.pipe_busy = |vld_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_kept   = kept_reg;
    assign out_slot   = slot_reg;
    assign out_left   = ol_reg;
    assign out_top    = ot_reg;
    assign out_right  = or_reg;
    assign out_bottom = ob_reg;
    assign out_score  = oscore_reg;
    assign out_last   = olast_reg;
    assign out_total  = total_reg;

    // reads stay inside the filled part of the table
    a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> idx_reg < count_reg)
        else $error("table read beyond fill count");

    // decision only after every compare has landed in the hit flag
    a_commit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(|vld_reg))
        else $error("commit with compares in flight");

    // a kept box that does not end the frame grows the table by one
    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && keep && !last_reg |=>
            count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("fill count did not advance on keep");

    // never store past the table end
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |-> count_reg < CNT_W'(MAX_KEPT))
        else $error("write into full table");

endmodule

FILE: hdl/greedy_box_suppression.sv
// Greedy box suppression top level: stream ports, field packing, controller and datapath.
// Each request is compared with the n kept boxes in the table, or with none when the table
//   is empty or full; a new request is taken only after the previous one has committed.
//   One table RAM read per kept box feeds a 5-stage overlap compare pipeline. The result
//   register lets the next request enter. A result that is not taken holds the commit, and
//   so the input.
// Reset: table fill count cleared, threshold back to 29491; table contents are not cleared.
module greedy_box_suppression
    import gbs_pkg::*;
#(
    parameter int MAX_KEPT   = MAX_KEPT_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    // threshold register write
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [THR_BITS-1:0] cfg_data,
    // candidates
    input  logic s_tvalid,
    output logic s_tready,
    // box_left, box_top, box_right, box_bottom, score
    input  logic [((4 * COORD_BITS + SCORE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    input  logic s_tlast,                  // last_in_frame
    // results
    output logic m_tvalid,
    input  logic m_tready,
    // kept_slot, kept_left, kept_top, kept_right, kept_bottom, kept_score, kept_total
    output logic [((2 * SLOT_BITS + 4 * COORD_BITS + SCORE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    output logic m_tuser,                  // kept
    output logic m_tlast                   // end_of_frame
);

    localparam int C     = COORD_BITS;
    localparam int OUT_W = ((2 * SLOT_BITS + 4 * COORD_BITS + SCORE_BITS + 7) / 8) * 8;

    gbs_cmd_t cmd;
    gbs_sts_t sts;

    logic signed [C-1:0]   o_left, o_top, o_right, o_bottom;
    logic [SCORE_BITS-1:0] o_score;
    logic [SLOT_BITS-1:0]  o_slot, o_total;

    assign cfg_ready = 1'b1;

    gbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gbs_dp #(
        .MAX_KEPT   (MAX_KEPT),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .in_left    ($signed(s_tdata[C-1:0])),
        .in_top     ($signed(s_tdata[2*C-1:C])),
        .in_right   ($signed(s_tdata[3*C-1:2*C])),
        .in_bottom  ($signed(s_tdata[4*C-1:3*C])),
        .in_score   (s_tdata[4*C+SCORE_BITS-1:4*C]),
        .in_last    (s_tlast),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kept   (m_tuser),
        .out_slot   (o_slot),
        .out_left   (o_left),
        .out_top    (o_top),
        .out_right  (o_right),
        .out_bottom (o_bottom),
        .out_score  (o_score),
        .out_last   (m_tlast),
        .out_total  (o_total)
    );

    assign m_tdata = OUT_W'({o_total, o_score, o_bottom, o_right, o_top, o_left, o_slot});

endmodule
